@@ hdl/bkst_pkg.sv @@
package bkst_pkg;

    localparam int unsigned KEY_SLOTS_DEF = 512;
    localparam int unsigned BUTTONS       = 5;
    localparam int unsigned BTN_W         = 3;
    localparam int unsigned KEY_W         = 9;
    localparam int unsigned ST_W          = 3;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned COORD_W       = 16;
    localparam int unsigned THR_W         = 8;
    localparam int unsigned OP_W          = 4;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 16;

    // Life cycle codes shared by buttons and keys.
    localparam logic [ST_W-1:0] ST_UP       = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESSED  = 3'd1;
    localparam logic [ST_W-1:0] ST_DOWN     = 3'd2;
    localparam logic [ST_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [ST_W-1:0] ST_PRESSREL = 3'd4;
    localparam logic [ST_W-1:0] ST_DCLICK   = 3'd5;
    localparam logic [ST_W-1:0] ST_DRAG     = 3'd6;

    localparam logic [OP_W-1:0] OP_PRESS     = 4'd0;
    localparam logic [OP_W-1:0] OP_RELEASE   = 4'd1;
    localparam logic [OP_W-1:0] OP_MOVE      = 4'd2;
    localparam logic [OP_W-1:0] OP_WHEEL     = 4'd3;
    localparam logic [OP_W-1:0] OP_KEY_DOWN  = 4'd4;
    localparam logic [OP_W-1:0] OP_KEY_UP    = 4'd5;
    localparam logic [OP_W-1:0] OP_FRAME     = 4'd6;
    localparam logic [OP_W-1:0] OP_UNFOCUS   = 4'd7;
    localparam logic [OP_W-1:0] OP_INIT      = 4'd8;
    localparam logic [OP_W-1:0] OP_QUERY_BTN = 4'd9;
    localparam logic [OP_W-1:0] OP_QUERY_KEY = 4'd10;

    localparam logic [BTN_W-1:0] BTN_MIDDLE   = 3'd2;
    localparam logic [BTN_W-1:0] BTN_WHEEL_UP = 3'd3;
    localparam logic [BTN_W-1:0] BTN_WHEEL_DN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DCLICK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_W    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_H    = 2'd3;

    localparam logic [15:0]      DCLICK_RST   = 16'd250;
    localparam logic [THR_W-1:0] DRAG_THR_RST = 8'd5;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BTN_W-1:0]   button;
        logic [KEY_W-1:0]   key_code;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [TIME_W-1:0]  now_ms;
        logic               middle_held;
        logic               wheel_up;
    } t_item;

    typedef struct packed {
        logic               is_down;
        logic               pressed_now;
        logic               released_now;
        logic               double_clicked;
        logic               dragging;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
    } t_result;

    typedef struct packed {
        logic [15:0]        dclick_ms;
        logic [THR_W-1:0]   drag_thr;
        logic [COORD_W-1:0] scr_w;
        logic [COORD_W-1:0] scr_h;
    } t_cfg;

    function automatic logic may_press(input logic [ST_W-1:0] s);
        return (s == ST_UP) || (s == ST_RELEASED) || (s == ST_PRESSREL);
    endfunction

    function automatic logic [ST_W-1:0] age(input logic [ST_W-1:0] s);
        logic [ST_W-1:0] r;
        r = s;
        if (s == ST_PRESSED) begin
            r = ST_DOWN;
        end else if (s == ST_RELEASED || s == ST_PRESSREL || s == ST_DCLICK) begin
            r = ST_UP;
        end
        return r;
    endfunction

    function automatic t_result make_result(input logic [ST_W-1:0] st,
                                            input logic [COORD_W-1:0] ox,
                                            input logic [COORD_W-1:0] oy);
        t_result r;
        r.is_down        = (st != ST_UP);
        r.pressed_now    = (st == ST_PRESSED) || (st == ST_PRESSREL) || (st == ST_DCLICK);
        r.released_now   = (st == ST_RELEASED) || (st == ST_PRESSREL) || (st == ST_DCLICK);
        r.double_clicked = (st == ST_DCLICK);
        r.dragging       = (st == ST_DRAG);
        r.origin_x       = ox;
        r.origin_y       = oy;
        return r;
    endfunction

endpackage

@@ hdl/bkst_stream_if.sv @@
interface bkst_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/bkst_ram.sv @@
module bkst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bkst_engine.sv @@
module bkst_engine #(
    parameter int unsigned KEY_SLOTS = bkst_pkg::KEY_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bkst_pkg::t_cfg  i_cfg,
    bkst_stream_if.sink     i_item,
    bkst_stream_if.source   o_result
);

    import bkst_pkg::*;

    localparam int unsigned KW = $clog2(KEY_SLOTS);
    localparam int unsigned CW = $clog2(KEY_SLOTS + 1);
    localparam int unsigned BW = TIME_W + ST_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_RPT_RD,
        S_RPT_OUT
    } t_fsm;

    typedef enum logic [1:0] {
        SW_CLEAR,
        SW_FRAME,
        SW_UNFOCUS,
        SW_INIT
    } t_sweep;

    t_fsm               r_fsm;
    t_sweep             r_mode;
    logic [CW-1:0]      r_cnt;
    logic               r_wr_pend;
    logic [KW-1:0]      r_wr_idx;
    t_item              r_it;
    logic [KW-1:0]      r_kaddr;
    logic               r_kvalid;
    logic               r_bvalid;
    logic               r_drag_btn;
    logic [COORD_W-1:0] r_org_x;
    logic [COORD_W-1:0] r_org_y;
    logic [COORD_W-1:0] r_ptr_x;
    logic [COORD_W-1:0] r_ptr_y;
    logic               r_mid_up;
    logic               r_out_vld;
    t_result            r_out;

    t_item              item;
    logic               accept;
    logic               out_free;
    logic [KW-1:0]      in_kaddr;
    logic               in_kvalid;
    logic               in_bvalid;

    logic               k_we;
    logic [KW-1:0]      k_waddr;
    logic [ST_W-1:0]    k_wdata;
    logic               k_re;
    logic [KW-1:0]      k_raddr;
    logic [ST_W-1:0]    k_rdata;

    logic               b_we;
    logic [BTN_W-1:0]   b_waddr;
    logic [BW-1:0]      b_wdata;
    logic               b_re;
    logic [BTN_W-1:0]   b_raddr;
    logic [BW-1:0]      b_rdata;
    logic [ST_W-1:0]    b_state;
    logic [TIME_W-1:0]  b_last;

    logic [TIME_W-1:0]  n_elapsed;
    logic               n_dclick;
    logic [COORD_W-1:0] n_dx;
    logic [COORD_W-1:0] n_dy;
    logic               n_far;
    logic [ST_W-1:0]    n_drag_state;
    logic [BTN_W-1:0]   n_wheel_idx;
    logic [ST_W-1:0]    n_rep;
    logic               n_out_load;
    logic               n_exec_done;
    logic               n_go_rpt;
    logic               n_drag_set;
    logic [COORD_W-1:0] n_org_x;
    logic [COORD_W-1:0] n_org_y;

    function automatic logic [ST_W-1:0] sweep_state(input t_sweep m,
                                                     input logic [ST_W-1:0] s);
        logic [ST_W-1:0] r;
        case (m)
            SW_FRAME: begin
                r = age(s);
            end
            SW_UNFOCUS: begin
                r = ST_RELEASED;
            end
            default: begin
                r = ST_UP;
            end
        endcase
        return r;
    endfunction

    assign item      = i_item.data;
    assign accept    = i_item.valid && i_item.ready;
    assign out_free  = !r_out_vld || o_result.ready;
    assign in_kaddr  = KW'(item.key_code);
    assign in_kvalid = (32'(item.key_code) < KEY_SLOTS);
    assign in_bvalid = (item.button < BTN_W'(BUTTONS));

    assign b_state = b_rdata[ST_W-1:0];
    assign b_last  = b_rdata[BW-1:ST_W];

    // Press timing against the button entry just read, and drag distance from the drag origin.
    assign n_elapsed   = r_it.now_ms - b_last;
    assign n_dclick    = (n_elapsed < TIME_W'(i_cfg.dclick_ms));
    assign n_dx        = (r_org_x > r_it.pos_x) ? (r_org_x - r_it.pos_x)
                                                : (r_it.pos_x - r_org_x);
    assign n_dy        = (r_org_y > r_it.pos_y) ? (r_org_y - r_it.pos_y)
                                                : (r_it.pos_y - r_org_y);
    assign n_far       = (n_dx > COORD_W'(i_cfg.drag_thr)) || (n_dy > COORD_W'(i_cfg.drag_thr));
    assign n_wheel_idx = r_it.wheel_up ? BTN_WHEEL_UP : BTN_WHEEL_DN;

    always_comb begin
        k_re         = 1'b0;
        k_raddr      = in_kaddr;
        k_we         = 1'b0;
        k_waddr      = r_kaddr;
        k_wdata      = ST_UP;
        b_re         = 1'b0;
        b_raddr      = item.button;
        b_we         = 1'b0;
        b_waddr      = r_it.button;
        b_wdata      = {b_last, ST_UP};
        n_rep        = ST_UP;
        n_out_load   = 1'b0;
        n_exec_done  = 1'b0;
        n_go_rpt     = 1'b0;
        n_drag_set   = 1'b0;
        n_drag_state = b_state;
        n_org_x      = r_org_x;
        n_org_y      = r_org_y;

        case (r_fsm)
            S_IDLE: begin
                if (accept) begin
                    if (item.op == OP_KEY_DOWN || item.op == OP_KEY_UP ||
                        item.op == OP_QUERY_KEY) begin
                        k_re = in_kvalid;
                    end else if (item.op == OP_MOVE) begin
                        b_re    = 1'b1;
                        b_raddr = BTN_W'(r_drag_btn);
                    end else if (item.op == OP_INIT) begin
                        n_org_x = {1'b0, i_cfg.scr_w[COORD_W-1:1]};
                        n_org_y = {1'b0, i_cfg.scr_h[COORD_W-1:1]};
                    end else if (item.op != OP_FRAME && item.op != OP_UNFOCUS) begin
                        b_re = in_bvalid;
                    end
                end
            end

            S_EXEC: begin
                if (out_free) begin
                    n_exec_done = 1'b1;
                    n_out_load  = 1'b1;
                    case (r_it.op)
                        OP_PRESS: begin
                            n_rep = r_bvalid ? b_state : ST_UP;
                            if (r_bvalid && may_press(b_state)) begin
                                b_we = 1'b1;
                                if (r_it.middle_held) begin
                                    b_wdata = {{TIME_W{1'b0}}, ST_PRESSED};
                                end else if (n_dclick) begin
                                    b_wdata = {{TIME_W{1'b0}}, ST_DCLICK};
                                end else begin
                                    b_wdata = {r_it.now_ms, ST_PRESSED};
                                end
                                n_rep = b_wdata[ST_W-1:0];
                                // Left and right presses anchor a possible drag.
                                if (r_it.button < BTN_MIDDLE) begin
                                    n_drag_set = 1'b1;
                                    n_org_x    = r_ptr_x;
                                    n_org_y    = r_ptr_y;
                                end
                            end
                        end
                        OP_RELEASE: begin
                            n_rep = r_bvalid ? b_state : ST_UP;
                            if (r_bvalid) begin
                                if (b_state == ST_PRESSED) begin
                                    b_we    = 1'b1;
                                    b_wdata = {b_last, ST_PRESSREL};
                                    n_rep   = ST_PRESSREL;
                                end else if (b_state == ST_DOWN || b_state == ST_DRAG ||
                                             b_state == ST_DCLICK) begin
                                    b_we    = 1'b1;
                                    b_wdata = {b_last, ST_RELEASED};
                                    n_rep   = ST_RELEASED;
                                end
                            end
                        end
                        OP_MOVE: begin
                            b_waddr = BTN_W'(r_drag_btn);
                            if (r_mid_up && (b_state == ST_PRESSED || b_state == ST_DOWN) &&
                                n_far) begin
                                b_we         = 1'b1;
                                b_wdata      = {b_last, ST_DRAG};
                                n_drag_state = ST_DRAG;
                            end
                            if (!r_bvalid) begin
                                n_rep = ST_UP;
                            end else if (r_it.button == BTN_W'(r_drag_btn)) begin
                                n_rep = n_drag_state;
                            end else begin
                                // Addressed button was not read; fetch it after the write.
                                n_out_load = 1'b0;
                                n_go_rpt   = 1'b1;
                            end
                        end
                        OP_WHEEL: begin
                            b_we    = 1'b1;
                            b_waddr = n_wheel_idx;
                            b_wdata = {r_it.now_ms, ST_PRESSED};
                            if (!r_bvalid) begin
                                n_rep = ST_UP;
                            end else if (r_it.button == n_wheel_idx) begin
                                n_rep = ST_PRESSED;
                            end else begin
                                n_rep = b_state;
                            end
                        end
                        OP_KEY_DOWN: begin
                            n_rep = r_kvalid ? k_rdata : ST_UP;
                            if (r_kvalid && may_press(k_rdata)) begin
                                k_we    = 1'b1;
                                k_wdata = ST_PRESSED;
                                n_rep   = ST_PRESSED;
                            end
                        end
                        OP_KEY_UP: begin
                            n_rep = r_kvalid ? k_rdata : ST_UP;
                            if (r_kvalid && k_rdata == ST_PRESSED) begin
                                k_we    = 1'b1;
                                k_wdata = ST_PRESSREL;
                                n_rep   = ST_PRESSREL;
                            end else if (r_kvalid && k_rdata == ST_DOWN) begin
                                k_we    = 1'b1;
                                k_wdata = ST_RELEASED;
                                n_rep   = ST_RELEASED;
                            end
                        end
                        OP_QUERY_KEY: begin
                            n_rep = r_kvalid ? k_rdata : ST_UP;
                        end
                        default: begin
                            n_rep = r_bvalid ? b_state : ST_UP;
                        end
                    endcase
                end
            end

            S_SWEEP: begin
                // Read entry r_cnt while writing back the entry read in the previous cycle.
                if (r_cnt != CW'(KEY_SLOTS)) begin
                    k_re    = 1'b1;
                    k_raddr = r_cnt[KW-1:0];
                    if (r_cnt < CW'(BUTTONS)) begin
                        b_re    = 1'b1;
                        b_raddr = r_cnt[BTN_W-1:0];
                    end
                end
                if (r_wr_pend) begin
                    k_we    = 1'b1;
                    k_waddr = r_wr_idx;
                    k_wdata = sweep_state(r_mode, k_rdata);
                    if (r_wr_idx < KW'(BUTTONS)) begin
                        b_we    = 1'b1;
                        b_waddr = r_wr_idx[BTN_W-1:0];
                        b_wdata = {(r_mode == SW_CLEAR) ? {TIME_W{1'b0}} : b_last,
                                   sweep_state(r_mode, b_state)};
                    end
                end
            end

            S_RPT_RD: begin
                b_re    = r_bvalid;
                b_raddr = r_it.button;
            end

            S_RPT_OUT: begin
                if (out_free) begin
                    n_out_load = 1'b1;
                    n_rep      = r_bvalid ? b_state : ST_UP;
                end
            end

            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_SWEEP;
            r_mode     <= SW_CLEAR;
            r_cnt      <= '0;
            r_wr_pend  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_drag_btn <= 1'b0;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_ptr_x    <= '0;
            r_ptr_y    <= '0;
            r_mid_up   <= 1'b1;
        end else begin
            r_org_x <= n_org_x;
            r_org_y <= n_org_y;

            if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            if (n_out_load) begin
                r_out_vld <= 1'b1;
                r_out     <= make_result(n_rep, n_org_x, n_org_y);
            end

            if (b_we && b_waddr == BTN_MIDDLE) begin
                r_mid_up <= (b_wdata[ST_W-1:0] == ST_UP);
            end
            if (n_drag_set) begin
                r_drag_btn <= r_it.button[0];
            end

            case (r_fsm)
                S_IDLE: begin
                    if (accept) begin
                        r_it      <= item;
                        r_kaddr   <= in_kaddr;
                        r_kvalid  <= in_kvalid;
                        r_bvalid  <= in_bvalid;
                        r_cnt     <= '0;
                        r_wr_pend <= 1'b0;
                        case (item.op)
                            OP_FRAME: begin
                                r_mode <= SW_FRAME;
                                r_fsm  <= S_SWEEP;
                            end
                            OP_UNFOCUS: begin
                                r_mode <= SW_UNFOCUS;
                                r_fsm  <= S_SWEEP;
                            end
                            OP_INIT: begin
                                r_mode     <= SW_INIT;
                                r_fsm      <= S_SWEEP;
                                r_drag_btn <= 1'b0;
                            end
                            default: begin
                                r_fsm <= S_EXEC;
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    if (n_exec_done) begin
                        if (r_it.op == OP_MOVE) begin
                            r_ptr_x <= r_it.pos_x;
                            r_ptr_y <= r_it.pos_y;
                        end
                        r_fsm <= n_go_rpt ? S_RPT_RD : S_IDLE;
                    end
                end
                S_SWEEP: begin
                    r_wr_pend <= (r_cnt != CW'(KEY_SLOTS));
                    r_wr_idx  <= r_cnt[KW-1:0];
                    if (r_cnt != CW'(KEY_SLOTS)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_fsm <= (r_mode == SW_CLEAR) ? S_IDLE : S_RPT_RD;
                    end
                end
                S_RPT_RD: begin
                    r_fsm <= S_RPT_OUT;
                end
                S_RPT_OUT: begin
                    if (out_free) begin
                        r_fsm <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready   = (r_fsm == S_IDLE);
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    bkst_ram #(
        .WIDTH (ST_W),
        .DEPTH (KEY_SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_re    (k_re),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    bkst_ram #(
        .WIDTH (BW),
        .DEPTH (BUTTONS)
    ) u_btn_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

endmodule

@@ hdl/button_key_state_tracker.sv @@
// Pointer button and key state tracker. Each input word carries one event (press, release,
// move, wheel, key down, key up, frame, focus loss, init or a query) and yields exactly one
// result word with the flags of the addressed button or key and the current drag origin.
// Key states live in a KEY_SLOTS-entry memory and button states with their last press time
// in a five-entry memory, both with a registered read; every event but a query is a
// read-modify-write through them. Press, release, wheel, key events and queries read the
// entry when the word is accepted, then update it and load the output register once that
// register is free. A move whose addressed button is not the drag button reads the
// addressed button again after the drag button has been written. Frame, focus loss and
// init walk the whole key table one entry per cycle. After reset the block clears both
// memories in a pass during which no input word is accepted; configuration writes are
// taken at any time but must only be issued while the block is idle. The output register
// holds a finished result while the next input word is accepted and started.
module button_key_state_tracker #(
    parameter int unsigned KEY_SLOTS = bkst_pkg::KEY_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bkst_stream_if.sink                        i_item,
    bkst_stream_if.source                      o_result,
    input  logic                               i_cfg_we,
    input  logic [bkst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bkst_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import bkst_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] r_pend;
    logic [1:0] n_pend;

    // Configuration registers; unused upper data bits are dropped per register width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dclick_ms <= DCLICK_RST;
            r_cfg.drag_thr  <= DRAG_THR_RST;
            r_cfg.scr_w     <= '0;
            r_cfg.scr_h     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DCLICK: begin
                    r_cfg.dclick_ms <= i_cfg_data;
                end
                CFG_DRAG_THR: begin
                    r_cfg.drag_thr <= i_cfg_data[THR_W-1:0];
                end
                CFG_SCR_W: begin
                    r_cfg.scr_w <= i_cfg_data;
                end
                CFG_SCR_H: begin
                    r_cfg.scr_h <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    bkst_engine #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );

    // Words accepted whose result has not yet been taken.
    assign n_pend = r_pend + 2'(i_item.valid && i_item.ready)
                           - 2'(o_result.valid && o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // Only one word is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input accepted on the cycle after an acceptance");

    // When the block takes a new word, at most one earlier result is still waiting.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> (r_pend <= 2'd1))
        else $error("input ready with more than one result outstanding");

    // No result is offered without a word that caused it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0) |-> !o_result.valid)
        else $error("result offered with no word outstanding");

endmodule
